>>> rtl/rfc_pkg.sv
// shared constants and opcodes for the range flip / count bit array
// no dependencies
package rfc_pkg;

    localparam int NUM_BITS   = 4096;
    localparam int BLOCK_SIZE = 64;   // power of two
    localparam int NUM_BLOCKS = (NUM_BITS + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int FLD_W = 13;
    localparam int IDX_W = $clog2(NUM_BITS);
    localparam int OFF_W = $clog2(BLOCK_SIZE);
    localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCK_SIZE + 1);

    // offset of the last existing bit in the final block
    localparam int LAST_OFF = (NUM_BITS - 1) % BLOCK_SIZE;

    // popcount chunking of one block word
    localparam int CHUNK_W  = 8;
    localparam int N_CHUNKS = (BLOCK_SIZE + CHUNK_W - 1) / CHUNK_W;
    localparam int PC_W     = $clog2(CHUNK_W + 1);

    localparam logic OP_FLIP  = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    typedef logic [BLOCK_SIZE-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_cnt;

endpackage

>>> rtl/rfc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module rfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/range_flip_count_bit_array_unit.sv
// top level of the range flip / range count bit array
// depends on rfc_pkg and rfc_ram
//
// usage:
//   input channel (i_valid / o_stall) carries one request word: i_opcode,
//   i_range_start, i_range_end (1-based, inclusive). start 0 reads as 1, an
//   end past the array reads as the last bit, start past end is an empty range
//   flip requests invert the range and give no output word; count requests
//   give exactly one output word on o_valid / i_stall with o_set_count
//   the bits live in a block-wide word memory, with a second memory holding
//   a set-bit count per block; a request walks its blocks one per cycle
//   through a read / popcount / write-back pipeline
//   a count word passes the stage a, stage b and pending registers on its
//   way to the output register, and an empty count goes straight to the
//   pending register; the unit takes one request at a time
//   o_stall stays high while a request is in flight; a finished count waits
//   in the output register while i_stall is high, and the next request is
//   taken meanwhile
//   reset (synchronous, active low) clears all bits at once through per-block
//   valid flags; no clearing sweep is needed
module range_flip_count_bit_array_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_opcode,
    input  logic [rfc_pkg::FLD_W-1:0] i_range_start,
    input  logic [rfc_pkg::FLD_W-1:0] i_range_end,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [rfc_pkg::FLD_W-1:0] o_set_count
);

    localparam int BS  = rfc_pkg::BLOCK_SIZE;
    localparam int FW  = rfc_pkg::FLD_W;
    localparam int IW  = rfc_pkg::IDX_W;
    localparam int OW  = rfc_pkg::OFF_W;
    localparam int BW  = rfc_pkg::BLK_W;
    localparam int CW  = rfc_pkg::CNT_W;
    localparam int NCH = rfc_pkg::N_CHUNKS;
    localparam int PW  = rfc_pkg::PC_W;
    localparam int CHW = rfc_pkg::CHUNK_W;

    localparam logic [BW-1:0] LAST_BLK = BW'(rfc_pkg::NUM_BLOCKS - 1);

    // ---------------- request front end ----------------
    logic          w_accept;
    logic [FW-1:0] w_s, w_e;
    logic          w_empty;

    // request registers
    logic          r_run;      // still issuing block reads
    logic          r_op;
    logic [IW-1:0] r_sidx, r_eidx;
    logic [BW-1:0] r_blk;

    // stage a: block read data from the rams is valid together with these registers
    logic          r_a_vld, r_a_last, r_a_bv;
    logic [BW-1:0] r_a_blk;
    logic [OW-1:0] r_a_lo, r_a_hi;

    // stage b: masked word split into chunk popcounts
    logic                r_b_vld, r_b_last, r_b_full;
    logic [BW-1:0]       r_b_blk;
    rfc_pkg::t_word      r_b_word;
    rfc_pkg::t_cnt       r_b_cnt, r_b_plen, r_b_blen;
    logic [PW-1:0]       r_b_pc [NCH];

    // result hand-off
    logic          r_pend;
    logic [FW-1:0] r_pend_cnt;
    logic [FW-1:0] r_total;
    logic          r_out_vld;
    logic [FW-1:0] r_out_cnt;

    // per-block written flags: an unwritten block reads as all zero
    logic [rfc_pkg::NUM_BLOCKS-1:0] r_bvld;

    // memory ports
    rfc_pkg::t_word w_rd_word, w_wr_word;
    rfc_pkg::t_cnt  w_rd_cnt, w_wr_cnt;
    logic           w_wr_en;

    assign o_stall  = r_run | r_a_vld | r_b_vld | r_pend;
    assign w_accept = i_valid & ~o_stall;

    // range clamp
    always_comb begin
        w_s = (i_range_start == '0) ? FW'(1) : i_range_start;
        w_e = (i_range_end > FW'(rfc_pkg::NUM_BITS)) ? FW'(rfc_pkg::NUM_BITS) : i_range_end;
        w_empty = (w_s > w_e);
    end

    // ---------------- issue ----------------
    logic [BW-1:0] w_sblk, w_eblk;
    logic [OW-1:0] w_issue_lo, w_issue_hi;
    logic          w_issue_last;

    assign w_sblk = r_sidx[IW-1:IW-BW];
    assign w_eblk = r_eidx[IW-1:IW-BW];

    always_comb begin
        w_issue_last = (r_blk == w_eblk);
        w_issue_lo   = (r_blk == w_sblk) ? r_sidx[OW-1:0] : '0;
        w_issue_hi   = w_issue_last ? r_eidx[OW-1:0] : OW'(BS - 1);
    end

    // ---------------- stage b logic ----------------
    rfc_pkg::t_word w_word, w_mask, w_masked;
    rfc_pkg::t_cnt  w_cnt;
    logic           w_full;
    logic [OW-1:0]  w_last_off;

    always_comb begin
        w_word     = r_a_bv ? w_rd_word : '0;
        w_cnt      = r_a_bv ? w_rd_cnt : '0;
        w_mask     = ({BS{1'b1}} << r_a_lo) & ({BS{1'b1}} >> (OW'(BS - 1) - r_a_hi));
        w_masked   = w_word & w_mask;
        w_last_off = (r_a_blk == LAST_BLK) ? OW'(rfc_pkg::LAST_OFF) : OW'(BS - 1);
        w_full     = (r_a_lo == '0) && (r_a_hi == w_last_off);
    end

    // ---------------- stage c logic ----------------
    rfc_pkg::t_cnt w_pc, w_term;
    logic [FW-1:0] w_sum;

    always_comb begin
        w_pc = '0;
        for (int c = 0; c < NCH; c++) begin
            w_pc = w_pc + CW'(r_b_pc[c]);
        end
        w_term = r_b_full ? r_b_cnt : w_pc;
        // flipped count: full block inverts, partial adds cleared bits and drops set ones
        w_wr_cnt  = r_b_full ? (r_b_blen - r_b_cnt)
                             : (r_b_cnt + r_b_plen - {w_pc[CW-2:0], 1'b0});
        w_wr_word = r_b_word;
        w_wr_en   = r_b_vld && (r_op == rfc_pkg::OP_FLIP);
        w_sum     = r_total + FW'(w_term);
    end

    // ---------------- memories ----------------
    rfc_ram #(.WIDTH(BS), .DEPTH(rfc_pkg::NUM_BLOCKS)) u_word_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_b_blk),
        .i_wr_data (w_wr_word),
        .i_rd_addr (r_blk),
        .o_rd_data (w_rd_word)
    );

    rfc_ram #(.WIDTH(CW), .DEPTH(rfc_pkg::NUM_BLOCKS)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_b_blk),
        .i_wr_data (w_wr_cnt),
        .i_rd_addr (r_blk),
        .o_rd_data (w_rd_cnt)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_bvld    <= '0;
        end else begin
            // issue one block per cycle
            r_a_vld <= r_run;
            if (r_run && w_issue_last) begin
                r_run <= 1'b0;
            end
            if (w_accept && !w_empty) begin
                r_run <= 1'b1;
            end

            r_b_vld <= r_a_vld;

            if (w_wr_en) begin
                r_bvld[r_b_blk] <= 1'b1;
            end

            // result pending: end of a count walk, or an empty count
            if (r_b_vld && r_b_last && (r_op == rfc_pkg::OP_COUNT)) begin
                r_pend <= 1'b1;
            end else if (w_accept && w_empty && (i_opcode == rfc_pkg::OP_COUNT)) begin
                r_pend <= 1'b1;
            end else if (r_pend && (!r_out_vld || !i_stall)) begin
                r_pend <= 1'b0;
            end

            // output register
            if (r_pend && (!r_out_vld || !i_stall)) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_sidx  <= IW'(w_s - FW'(1));
            r_eidx  <= IW'(w_s - FW'(1)) == '0 ? IW'(w_e - FW'(1)) : IW'(w_e - FW'(1));
            r_blk   <= BW'(IW'(w_s - FW'(1)) >> OW);
            r_total <= '0;
        end else if (r_run) begin
            r_blk <= r_blk + BW'(1);
        end

        r_a_blk  <= r_blk;
        r_a_lo   <= w_issue_lo;
        r_a_hi   <= w_issue_hi;
        r_a_last <= w_issue_last;
        r_a_bv   <= r_bvld[r_blk];

        r_b_blk  <= r_a_blk;
        r_b_last <= r_a_last;
        r_b_full <= w_full;
        r_b_cnt  <= w_cnt;
        r_b_word <= w_word ^ w_mask;
        r_b_plen <= CW'(r_a_hi) - CW'(r_a_lo) + CW'(1);
        r_b_blen <= CW'(w_last_off) + CW'(1);
        for (int c = 0; c < NCH; c++) begin
            logic [PW-1:0] v_pc;
            v_pc = '0;
            for (int b = 0; b < CHW; b++) begin
                if (c * CHW + b < BS) begin
                    v_pc = v_pc + PW'(w_masked[c * CHW + b]);
                end
            end
            r_b_pc[c] <= v_pc;
        end

        if (r_b_vld) begin
            r_total <= w_sum;
        end
        if (r_b_vld && r_b_last) begin
            r_pend_cnt <= w_sum;
        end else if (w_accept && w_empty) begin
            r_pend_cnt <= '0;
        end

        if (r_pend && (!r_out_vld || !i_stall)) begin
            r_out_cnt <= r_pend_cnt;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_set_count = r_out_cnt;

endmodule

>>> tb/sv/range_flip_count_checker.sv
// result checker for range_flip_count_bit_array_unit: watches both channels,
// keeps its own copy of the bit array and block counts, and compares every count word
// depends on rfc_pkg
module range_flip_count_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic                      i_req_stall,
    input  logic                      i_opcode,
    input  logic [rfc_pkg::FLD_W-1:0] i_range_start,
    input  logic [rfc_pkg::FLD_W-1:0] i_range_end,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic [rfc_pkg::FLD_W-1:0] i_set_count,
    output int                        o_fail_count,
    output int                        o_pending_counts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   FLD_W      = rfc_pkg::FLD_W;
    localparam int   NUM_BITS   = rfc_pkg::NUM_BITS;
    localparam int   BLOCK_SIZE = rfc_pkg::BLOCK_SIZE;
    localparam int   NUM_BLOCKS = rfc_pkg::NUM_BLOCKS;
    localparam logic OP_FLIP    = rfc_pkg::OP_FLIP;

    logic [NUM_BITS-1:0] mirror_bits;
    int unsigned         block_tally [NUM_BLOCKS];
    logic [FLD_W-1:0]    expected_counts [$];
    int                  fail_total = 0;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // start 0 reads as 1, end past the array reads as the last bit
    function automatic bit clamp_span(input logic [FLD_W-1:0] raw_first,
                                      input logic [FLD_W-1:0] raw_last,
                                      output int unsigned first,
                                      output int unsigned last);
        first = 32'(raw_first);
        last  = 32'(raw_last);
        if (first == 0) first = 1;
        if (last > NUM_BITS) last = NUM_BITS;
        return first <= last;
    endfunction

    function automatic void flip_span(input int unsigned first, input int unsigned last);
        int unsigned idx;
        for (idx = first - 1; idx < last; idx++) begin
            mirror_bits[idx] = ~mirror_bits[idx];
            if (mirror_bits[idx]) block_tally[idx / BLOCK_SIZE]++;
            else block_tally[idx / BLOCK_SIZE]--;
        end
    endfunction

    // whole blocks from the tallies, partial edges bit by bit
    function automatic int unsigned count_span(input int unsigned first,
                                               input int unsigned last);
        int unsigned total, idx, blk, blk_first, blk_last;
        total = 0;
        idx   = first - 1;
        while (idx <= last - 1) begin
            blk       = idx / BLOCK_SIZE;
            blk_first = blk * BLOCK_SIZE;
            blk_last  = blk_first + BLOCK_SIZE - 1;
            if (blk_last > NUM_BITS - 1) blk_last = NUM_BITS - 1;
            if (idx == blk_first && blk_last <= last - 1) begin
                total += block_tally[blk];
                idx = blk_last + 1;
            end else begin
                total += 32'(mirror_bits[idx]);
                idx++;
            end
        end
        return total;
    endfunction

    always @(posedge i_clk) begin : watch
        int unsigned      first, last;
        bit               nonempty;
        logic [FLD_W-1:0] want;
        if (!i_rst_n) begin
            mirror_bits = '0;
            foreach (block_tally[k]) block_tally[k] = 0;
            expected_counts.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("count word %0d with none pending", i_set_count));
                end else begin
                    want = expected_counts.pop_front();
                    if (i_set_count !== want) begin
                        report_mismatch($sformatf("set_count got %0d, expected %0d",
                                                  i_set_count, want));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                nonempty = clamp_span(i_range_start, i_range_end, first, last);
                if (i_opcode == OP_FLIP) begin
                    if (nonempty) flip_span(first, last);
                end else begin
                    want = '0;
                    if (nonempty) want = FLD_W'(count_span(first, last));
                    expected_counts.push_back(want);
                end
            end
        end
        o_pending_counts <= expected_counts.size();
        o_fail_count     <= fail_total;
    end

endmodule

>>> tb/sv/range_flip_count_bit_array_unit_test.sv
// top of the range flip / count bit array testbench: clock, reset, request and
// result drivers, watchdog and verdict
// depends on rfc_pkg, range_flip_count_bit_array_unit and range_flip_count_checker
module range_flip_count_bit_array_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   FLD_W      = rfc_pkg::FLD_W;
    localparam int   NUM_BITS   = rfc_pkg::NUM_BITS;
    localparam int   BLOCK_SIZE = rfc_pkg::BLOCK_SIZE;
    localparam int   NUM_BLOCKS = rfc_pkg::NUM_BLOCKS;
    localparam logic OP_FLIP    = rfc_pkg::OP_FLIP;
    localparam logic OP_COUNT   = rfc_pkg::OP_COUNT;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int LONG_HOLD      = 400;   // result side held off this many cycles
    localparam int DRAIN_CYCLES   = 100;   // idle wait after the final drain
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             req_valid  = 1'b0;
    logic             req_stall;
    logic             req_opcode = OP_FLIP;
    logic [FLD_W-1:0] req_start  = '0;
    logic [FLD_W-1:0] req_end    = '0;
    logic             res_valid;
    logic             res_stall  = 1'b0;
    logic [FLD_W-1:0] res_count;

    int fail_count;
    int pending_counts;

    // run-shape knobs, set by the stimulus process
    bit sender_idling   = 1'b1;
    bit receiver_idling = 1'b1;
    int hold_requests   = 0;

    // tallies for the closing summary
    int flip_words  = 0;
    int count_words = 0;
    int odd_ranges  = 0;
    int holds_done  = 0;
    int drains_done = 0;
    int idle_cycles = 0;

    range_flip_count_bit_array_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_stall       (req_stall),
        .i_opcode      (req_opcode),
        .i_range_start (req_start),
        .i_range_end   (req_end),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_set_count   (res_count)
    );

    range_flip_count_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_stall      (req_stall),
        .i_opcode         (req_opcode),
        .i_range_start    (req_start),
        .i_range_end      (req_end),
        .i_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .i_set_count      (res_count),
        .o_fail_count     (fail_count),
        .o_pending_counts (pending_counts)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stall bursts, or one long hold-off on request
    always begin
        @(posedge clk);
        if (holds_done < hold_requests) begin
            res_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            res_stall <= 1'b0;
            holds_done++;
        end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
            res_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            res_stall <= 1'b0;
        end
    end

    // offer one request word and hold it until taken; called right after a
    // rising edge, returns after the edge that took the word, or after a gap burst
    task automatic send_word(input logic op, input logic [FLD_W-1:0] first,
                             input logic [FLD_W-1:0] last);
        req_valid  <= 1'b1;
        req_opcode <= op;
        req_start  <= first;
        req_end    <= last;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (op == OP_FLIP) flip_words++;
        else count_words++;
        if (first == 0 || last > NUM_BITS || first > last) odd_ranges++;
        // sender gap burst
        if (sender_idling && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // random requests: mostly legal ranges of mixed length, some block
    // aligned, and a tenth raw 13-bit noise (zero start, past the end, reversed)
    task automatic send_random_words(input int n, input bit counts_only);
        logic             op;
        logic [FLD_W-1:0] first, last;
        int unsigned      kind, lo, hi;
        repeat (n) begin
            op   = counts_only ? OP_COUNT : 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            lo   = $urandom_range(1, NUM_BITS);
            hi   = lo;
            if (kind <= 3) begin
                hi = lo + $urandom_range(0, BLOCK_SIZE - 1);
            end else if (kind <= 5) begin
                hi = lo + $urandom_range(0, 4 * BLOCK_SIZE);
            end else if (kind == 6) begin
                hi = lo + $urandom_range(0, NUM_BITS);
            end else if (kind <= 8) begin
                lo = $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_SIZE + 1;
                hi = lo + $urandom_range(1, 8) * BLOCK_SIZE - 1;
            end
            if (hi > NUM_BITS) hi = NUM_BITS;
            first = FLD_W'(lo);
            last  = FLD_W'(hi);
            if (kind == 9) begin
                first = FLD_W'($urandom);
                last  = FLD_W'($urandom);
            end
            send_word(op, first, last);
        end
    endtask

    // stop offering and wait until every pending count word has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts != 0) @(posedge clk);
        drains_done++;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: array empty after reset, then full-range flip and count
        send_word(OP_COUNT, FLD_W'(1), FLD_W'(NUM_BITS));
        send_word(OP_FLIP, FLD_W'(1), FLD_W'(NUM_BITS));
        send_word(OP_COUNT, FLD_W'(1), FLD_W'(NUM_BITS));
        // first and last single bits
        send_word(OP_FLIP, FLD_W'(1), FLD_W'(1));
        send_word(OP_FLIP, FLD_W'(NUM_BITS), FLD_W'(NUM_BITS));
        send_word(OP_COUNT, FLD_W'(1), FLD_W'(1));
        send_word(OP_COUNT, FLD_W'(NUM_BITS), FLD_W'(NUM_BITS));
        // zero start reads as bit one
        send_word(OP_FLIP, FLD_W'(0), FLD_W'(10));
        send_word(OP_COUNT, FLD_W'(0), FLD_W'(10));
        send_word(OP_COUNT, FLD_W'(0), FLD_W'(0));
        // end past the array is clamped to the last bit
        send_word(OP_FLIP, FLD_W'(4090), 13'h1FFF);
        send_word(OP_COUNT, FLD_W'(4000), 13'h1FFF);
        // reversed and fully out-of-range starts give an empty range
        send_word(OP_FLIP, FLD_W'(100), FLD_W'(50));
        send_word(OP_COUNT, FLD_W'(100), FLD_W'(50));
        send_word(OP_COUNT, FLD_W'(5000), 13'h1FFF);
        send_word(OP_FLIP, 13'h1FFF, 13'h1FFF);
        // ranges inside one block, an exact block, and partial edges
        send_word(OP_FLIP, FLD_W'(70), FLD_W'(100));
        send_word(OP_COUNT, FLD_W'(70), FLD_W'(90));
        send_word(OP_COUNT, FLD_W'(BLOCK_SIZE + 1), FLD_W'(2 * BLOCK_SIZE));
        send_word(OP_FLIP, FLD_W'(BLOCK_SIZE - 1), FLD_W'(BLOCK_SIZE + 2));
        send_word(OP_COUNT, FLD_W'(30), FLD_W'(200));
        send_word(OP_COUNT, FLD_W'(BLOCK_SIZE - 4), FLD_W'(BLOCK_SIZE + 6));
        send_word(OP_COUNT, FLD_W'(1), FLD_W'(NUM_BITS));
        wait_drained();

        send_random_words(300, 1'b0);

        // long result hold-off while counts keep coming, so the block fills
        // its output register and stalls the request side
        hold_requests = hold_requests + 1;
        send_random_words(30, 1'b1);
        wait_drained();

        send_random_words(380, 1'b0);
        wait_drained();

        // last stretch runs without gaps on either side
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        send_random_words(200, 1'b0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d flip words and %0d count words, %0d with clamped or empty ranges",
                 flip_words, count_words, odd_ranges);
        $display("with %0d long result hold-off(s) and %0d full drains, %0d mismatches",
                 holds_done, drains_done, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
